// ----- rtl/core/csl_pkg.sv -----
package csl_pkg;

    // Result kinds as they appear on the kind field
    typedef enum logic [3:0] {
        K_TEXT = 4'd0,
        K_EOF  = 4'd1,
        K_NUM  = 4'd2,
        K_CHR  = 4'd3,
        K_STR  = 4'd4,
        K_OP   = 4'd5,
        K_SEP  = 4'd6,
        K_ID   = 4'd7,
        K_KW   = 4'd8,
        K_ERR  = 4'd9
    } t_kind;

    // Scanner modes
    typedef enum logic [3:0] {
        M_IDLE,
        M_NUM0,
        M_NUM,
        M_IDENT,
        M_STR,
        M_STR_ESC,
        M_CHR_OPEN,
        M_CHR_ESC,
        M_CHR_CLOSE,
        M_OP1,
        M_SHIFT,
        M_COMMENT
    } t_mode;

    // One result beat without the value and line fields
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text;
        logic [4:0]  radix;
        logic [7:0]  sub;
    } t_res;

    localparam int NUM_KW   = 10;
    localparam int MAX_RES  = 3;

    // Operator codes
    localparam logic [7:0] OP_ASSIGN  = 8'd0;
    localparam logic [7:0] OP_INC     = 8'd1;
    localparam logic [7:0] OP_DEC     = 8'd2;
    localparam logic [7:0] OP_BNOT    = 8'd3;
    localparam logic [7:0] OP_LNOT    = 8'd4;
    localparam logic [7:0] OP_EQ      = 8'd5;
    localparam logic [7:0] OP_NE      = 8'd6;
    localparam logic [7:0] OP_LT      = 8'd7;
    localparam logic [7:0] OP_GT      = 8'd8;
    localparam logic [7:0] OP_LE      = 8'd9;
    localparam logic [7:0] OP_GE      = 8'd10;
    localparam logic [7:0] OP_ADD     = 8'd11;
    localparam logic [7:0] OP_SUB     = 8'd12;
    localparam logic [7:0] OP_MUL     = 8'd13;
    localparam logic [7:0] OP_DIV     = 8'd14;
    localparam logic [7:0] OP_MOD     = 8'd15;
    localparam logic [7:0] OP_SHL     = 8'd16;
    localparam logic [7:0] OP_SHR     = 8'd17;
    localparam logic [7:0] OP_AND     = 8'd18;
    localparam logic [7:0] OP_OR      = 8'd19;
    localparam logic [7:0] OP_XOR     = 8'd20;
    localparam logic [7:0] OP_LAND    = 8'd21;
    localparam logic [7:0] OP_LOR     = 8'd22;
    localparam logic [7:0] OP_ADD_EQ  = 8'd23;
    localparam logic [7:0] OP_SUB_EQ  = 8'd24;
    localparam logic [7:0] OP_MUL_EQ  = 8'd25;
    localparam logic [7:0] OP_DIV_EQ  = 8'd26;
    localparam logic [7:0] OP_MOD_EQ  = 8'd27;
    localparam logic [7:0] OP_SHL_EQ  = 8'd28;
    localparam logic [7:0] OP_SHR_EQ  = 8'd29;
    localparam logic [7:0] OP_AND_EQ  = 8'd30;
    localparam logic [7:0] OP_OR_EQ   = 8'd31;
    localparam logic [7:0] OP_XOR_EQ  = 8'd32;

    // Keyword spellings, first character in the top byte, zero padded
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        {"void",   16'h0},
        {"char",   16'h0},
        {"int",    24'h0},
        {"enum",   16'h0},
        {"if",     32'h0},
        {"else",   16'h0},
        {"while",   8'h0},
        {"for",    24'h0},
        {"return"},
        {"sizeof"}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd4, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd6
    };

    function automatic t_res mk_res(t_kind kind, logic [7:0] text,
                                    logic [4:0] radix, logic [7:0] sub);
        t_res r;
        r.kind  = kind;
        r.text  = text;
        r.radix = radix;
        r.sub   = sub;
        return r;
    endfunction

    // Digit value for radix up to 16, or 16 when not a hex digit
    function automatic logic [4:0] digit_val(logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= "0" && c <= "9") d = 5'(c - "0");
        else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
        return d;
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [7:0] escape_char(logic [7:0] c);
        logic [7:0] e;
        unique case (c)
            "n":     e = 8'h0a;
            "r":     e = 8'h0d;
            "t":     e = 8'h09;
            "b":     e = 8'h08;
            "0":     e = 8'h00;
            default: e = c;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] op_single(logic [7:0] p);
        logic [7:0] o;
        unique case (p)
            "<":     o = OP_LT;
            ">":     o = OP_GT;
            "=":     o = OP_ASSIGN;
            "*":     o = OP_MUL;
            "+":     o = OP_ADD;
            "-":     o = OP_SUB;
            "&":     o = OP_AND;
            "|":     o = OP_OR;
            "/":     o = OP_DIV;
            "%":     o = OP_MOD;
            "^":     o = OP_XOR;
            default: o = OP_LNOT;
        endcase
        return o;
    endfunction

    function automatic logic [7:0] op_assign(logic [7:0] p);
        logic [7:0] o;
        unique case (p)
            "<":     o = OP_LE;
            ">":     o = OP_GE;
            "=":     o = OP_EQ;
            "*":     o = OP_MUL_EQ;
            "+":     o = OP_ADD_EQ;
            "-":     o = OP_SUB_EQ;
            "&":     o = OP_AND_EQ;
            "|":     o = OP_OR_EQ;
            "/":     o = OP_DIV_EQ;
            "%":     o = OP_MOD_EQ;
            "^":     o = OP_XOR_EQ;
            default: o = OP_NE;
        endcase
        return o;
    endfunction

endpackage

// ----- rtl/core/csl_scan.sv -----
module csl_scan #(
    parameter int VALUE_BITS = 32,
    parameter int LINE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [7:0]                          i_byte,
    input  logic                                i_end,
    output csl_pkg::t_res [2:0]                 o_res,
    output logic [2:0][VALUE_BITS-1:0]          o_val,
    output logic [1:0]                          o_cnt,
    output logic [LINE_BITS-1:0]                o_line
);
    import csl_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    t_mode                  r_mode,  n_mode;
    logic [7:0]             r_pend,  n_pend;
    logic [VALUE_BITS-1:0]  r_acc,   n_acc;
    logic [4:0]             r_radix, n_radix;
    logic                   r_stop,  n_stop;
    logic [NUM_KW-1:0]      r_cand,  n_cand;
    logic [2:0]             r_len,   n_len;
    logic [7:0]             r_chr,   n_chr;
    logic [LINE_BITS-1:0]   r_line,  n_line;

    t_res                   pre0, pre1, st0, st1;
    logic [1:0]             pcnt, scnt;
    logic [VALUE_BITS-1:0]  pre_value;
    logic                   do_start, do_num;
    logic [4:0]             radix_eff, dval;
    logic [VALUE_BITS-1:0]  acc_mul;
    logic [7:0]             c;

    // Narrow the keyword candidates by one more character
    function automatic logic [NUM_KW-1:0] kw_feed(logic [NUM_KW-1:0] cand,
                                                 logic [2:0] p, logic [7:0] ch);
        logic [NUM_KW-1:0] nc;
        nc = cand;
        if (p >= 3'd6) begin
            nc = '0;
        end else begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (KW_TEXT[k][47 - 8*p -: 8] != ch) nc[k] = 1'b0;
            end
        end
        return nc;
    endfunction

    function automatic t_res ident_res(logic [NUM_KW-1:0] cand, logic [2:0] len);
        t_res r;
        r = mk_res(K_ID, 8'd0, 5'd0, 8'd0);
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (cand[k] && KW_LEN[k] == len) r = mk_res(K_KW, 8'd0, 5'd0, 8'(k));
        end
        return r;
    endfunction

    assign c = i_byte;

    // Multiply the accumulator by the radix with shifts
    always_comb begin
        unique case (radix_eff)
            5'd2:    acc_mul = r_acc << 1;
            5'd8:    acc_mul = r_acc << 3;
            5'd16:   acc_mul = r_acc << 4;
            default: acc_mul = (r_acc << 3) + (r_acc << 1);
        endcase
    end

    assign dval = digit_val(c);

    // Step the scanner on one byte
    always_comb begin
        n_mode = r_mode;  n_pend = r_pend;  n_acc = r_acc;  n_radix = r_radix;
        n_stop = r_stop;  n_cand = r_cand;  n_len = r_len;  n_chr = r_chr;
        n_line = r_line;
        pre0 = '0; pre1 = '0; st0 = '0; st1 = '0;
        pcnt = 2'd0; scnt = 2'd0;
        pre_value = '0;
        do_start = 1'b0;
        do_num = 1'b0;
        radix_eff = r_radix;

        if (i_end) begin
            // flush pending token, then end of file
            pcnt = 2'd1;
            unique case (r_mode)
                M_NUM0, M_NUM: begin
                    pre0 = mk_res(K_NUM, 8'd0, r_radix, 8'd0);
                    pre_value = r_acc;
                end
                M_IDENT: pre0 = ident_res(r_cand, r_len);
                M_STR, M_STR_ESC, M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE:
                    pre0 = mk_res(K_ERR, 8'd0, 5'd0, 8'd0);
                M_OP1: pre0 = mk_res(K_OP, 8'd0, 5'd0, op_single(r_pend));
                M_SHIFT: pre0 = mk_res(K_OP, 8'd0, 5'd0,
                                       r_pend == ">" ? OP_SHR : OP_SHL);
                default: pcnt = 2'd0;
            endcase
            if (pcnt == 2'd1) begin
                pre1 = mk_res(K_EOF, 8'd0, 5'd0, 8'd0);
                pcnt = 2'd2;
            end else begin
                pre0 = mk_res(K_EOF, 8'd0, 5'd0, 8'd0);
                pcnt = 2'd1;
            end
            n_mode = M_IDLE;  n_pend = '0;  n_acc = '0;  n_radix = 5'd10;
            n_stop = 1'b0;    n_cand = '1;  n_len = '0;  n_chr = '0;
            n_line = LINE_ONE;
        end else begin
            unique case (r_mode)
                M_NUM0: begin
                    if (c == "b" || c == "B" || c == "x" || c == "X") begin
                        pre0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                        pcnt = 2'd1;
                        n_radix = (c == "b" || c == "B") ? 5'd2 : 5'd16;
                        n_acc = '0;
                        n_mode = M_NUM;
                    end else begin
                        radix_eff = (c >= "0" && c <= "7") ? 5'd8 : 5'd10;
                        n_radix = radix_eff;
                        n_mode = M_NUM;
                        do_num = 1'b1;
                    end
                end
                M_NUM: do_num = 1'b1;
                M_IDENT: begin
                    if (is_ident(c)) begin
                        n_cand = kw_feed(r_cand, r_len, c);
                        n_len = (r_len < 3'd7) ? r_len + 3'd1 : 3'd7;
                        pre0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                        pcnt = 2'd1;
                    end else begin
                        pre0 = ident_res(r_cand, r_len);
                        pcnt = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == "\"") begin
                        pre0 = mk_res(K_STR, 8'd0, 5'd0, 8'd0);
                        pcnt = 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == "\\") begin
                        n_mode = M_STR_ESC;
                    end else begin
                        pre0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                        pcnt = 2'd1;
                    end
                end
                M_STR_ESC: begin
                    pre0 = mk_res(K_TEXT, escape_char(c), 5'd0, 8'd0);
                    pcnt = 2'd1;
                    n_mode = M_STR;
                end
                M_CHR_OPEN: begin
                    if (c == "\\") begin
                        n_mode = M_CHR_ESC;
                    end else begin
                        n_chr = c;
                        n_mode = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC: begin
                    n_chr = escape_char(c);
                    n_mode = M_CHR_CLOSE;
                end
                M_CHR_CLOSE: begin
                    pcnt = 2'd1;
                    if (c == "'") begin
                        pre0 = mk_res(K_CHR, 8'd0, 5'd0, 8'd0);
                        pre_value = VALUE_BITS'(r_chr);
                        n_mode = M_IDLE;
                    end else begin
                        pre0 = mk_res(K_ERR, c, 5'd0, 8'd0);
                        do_start = 1'b1;
                    end
                end
                M_OP1: begin
                    if (c == "=") begin
                        pre0 = mk_res(K_OP, 8'd0, 5'd0, op_assign(r_pend));
                        pcnt = 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == r_pend && (r_pend == "<" || r_pend == ">")) begin
                        n_mode = M_SHIFT;
                    end else if (c == r_pend && r_pend == "/") begin
                        n_mode = M_COMMENT;
                    end else if (c == r_pend && (r_pend == "+" || r_pend == "-" ||
                                                 r_pend == "&" || r_pend == "|")) begin
                        pre0 = mk_res(K_OP, 8'd0, 5'd0,
                                      r_pend == "+" ? OP_INC :
                                      r_pend == "-" ? OP_DEC :
                                      r_pend == "&" ? OP_LAND : OP_LOR);
                        pcnt = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        pre0 = mk_res(K_OP, 8'd0, 5'd0, op_single(r_pend));
                        pcnt = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_SHIFT: begin
                    pcnt = 2'd1;
                    if (c == "=") begin
                        pre0 = mk_res(K_OP, 8'd0, 5'd0,
                                      r_pend == ">" ? OP_SHR_EQ : OP_SHL_EQ);
                        n_mode = M_IDLE;
                    end else begin
                        pre0 = mk_res(K_OP, 8'd0, 5'd0,
                                      r_pend == ">" ? OP_SHR : OP_SHL);
                        do_start = 1'b1;
                    end
                end
                M_COMMENT: do_start = (c == 8'h0a);
                default: do_start = 1'b1;
            endcase

            // Number body: digits extend the token, anything else ends it
            if (do_num) begin
                pcnt = 2'd1;
                if (dval == 5'd16) begin
                    pre0 = mk_res(K_NUM, 8'd0, radix_eff, 8'd0);
                    pre_value = r_acc;
                    do_start = 1'b1;
                end else begin
                    pre0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                    if (!r_stop) begin
                        if (dval < radix_eff) n_acc = acc_mul + VALUE_BITS'(dval);
                        else n_stop = 1'b1;
                    end
                end
            end

            // Start a new token with this byte
            if (do_start) begin
                n_mode = M_IDLE;
                if (c == " " || c == 8'h0d || c == 8'h09) begin
                    scnt = 2'd0;
                end else if (c == 8'h0a) begin
                    if (r_line < LINE_TOP) n_line = r_line + LINE_ONE;
                end else if (c >= "0" && c <= "9") begin
                    st0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                    scnt = 2'd1;
                    n_radix = 5'd10;
                    n_stop = 1'b0;
                    n_acc = VALUE_BITS'(c - "0");
                    n_mode = (c == "0") ? M_NUM0 : M_NUM;
                end else if (is_ident(c)) begin
                    n_cand = kw_feed('1, 3'd0, c);
                    n_len = 3'd1;
                    st0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                    scnt = 2'd1;
                    n_mode = M_IDENT;
                end else begin
                    unique case (c)
                        "\"": n_mode = M_STR;
                        "'":  n_mode = M_CHR_OPEN;
                        "{", "}", "(", ")", "[", "]", ",", ";": begin
                            st0 = mk_res(K_SEP, 8'd0, 5'd0, c);
                            scnt = 2'd1;
                        end
                        "<", ">", "=", "*", "+", "-", "&", "|", "/", "%", "^", "!": begin
                            n_pend = c;
                            n_mode = M_OP1;
                        end
                        "~": begin
                            st0 = mk_res(K_OP, 8'd0, 5'd0, OP_BNOT);
                            scnt = 2'd1;
                        end
                        default: begin
                            st0 = mk_res(K_TEXT, c, 5'd0, 8'd0);
                            st1 = mk_res(K_ERR, c, 5'd0, 8'd0);
                            scnt = 2'd2;
                        end
                    endcase
                end
            end
        end
    end

    // Pack the results of this byte into slots
    always_comb begin
        o_res = '0;
        unique case (pcnt)
            2'd0: begin
                o_res[0] = st0;
                o_res[1] = st1;
            end
            2'd1: begin
                o_res[0] = pre0;
                o_res[1] = st0;
                o_res[2] = st1;
            end
            default: begin
                o_res[0] = pre0;
                o_res[1] = pre1;
                o_res[2] = st0;
            end
        endcase
        for (int i = 0; i < MAX_RES; i++) begin
            o_val[i] = (o_res[i].kind == K_NUM || o_res[i].kind == K_CHR) ?
                       pre_value : '0;
        end
    end

    assign o_cnt  = pcnt + scnt;
    assign o_line = r_line;

    // Hold scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pend  <= '0;
            r_acc   <= '0;
            r_radix <= 5'd10;
            r_stop  <= 1'b0;
            r_cand  <= '1;
            r_len   <= '0;
            r_chr   <= '0;
            r_line  <= LINE_ONE;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_acc   <= n_acc;
            r_radix <= n_radix;
            r_stop  <= n_stop;
            r_cand  <= n_cand;
            r_len   <= n_len;
            r_chr   <= n_chr;
            r_line  <= n_line;
        end
    end

endmodule

// ----- rtl/core/csl_outbuf.sv -----
module csl_outbuf #(
    parameter int VALUE_BITS = 32,
    parameter int LINE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  csl_pkg::t_res [2:0]             i_res,
    input  logic [2:0][VALUE_BITS-1:0]      i_val,
    input  logic [1:0]                      i_cnt,
    input  logic [LINE_BITS-1:0]            i_line,
    output logic                            o_can_load,
    output logic                            o_valid,
    input  logic                            i_ready,
    output csl_pkg::t_res                   o_res,
    output logic [VALUE_BITS-1:0]           o_val,
    output logic [LINE_BITS-1:0]            o_line,
    output logic                            o_last
);
    import csl_pkg::*;

    t_res                   r_res [MAX_RES];
    logic [VALUE_BITS-1:0]  r_val [MAX_RES];
    logic [1:0]             r_cnt;
    logic [1:0]             r_idx;
    logic [LINE_BITS-1:0]   r_line;

    assign o_valid    = r_idx < r_cnt;
    assign o_last     = r_idx == r_cnt - 2'd1;
    assign o_can_load = !o_valid || (i_ready && o_last);
    assign o_res      = r_res[r_idx];
    assign o_val      = r_val[r_idx];
    assign o_line     = r_line;

    // Hold the payload of one byte's results
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_res[i] <= i_res[i];
                r_val[i] <= i_val[i];
            end
            r_line <= i_line;
        end
    end

    // Advance through the slots one beat at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ----- rtl/core/c_subset_lexer_unit.sv -----
// Streaming C-subset lexer.
// Input channel: one source byte per beat (i_in_byte), or an end marker
// (i_end_of_input) that flushes any pending token, emits Eof and returns the
// scanner to its reset state so the next source starts at line 1.
// Output channel: one result per beat: text bytes of identifiers, numbers and
// strings and bad bytes, then token results (number, char, string, operator,
// separator, identifier, keyword, error, Eof). o_last_result marks the final
// result caused by one input byte; a byte may cause zero to three results.
// An accepted byte waits in the input register, then its results load into
// the output slots; further results follow one a cycle while i_ready is high.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver is ready; a byte with more results holds the input until
// the single output port has drained the result slots.
// A stalled receiver holds the current result; the input register still
// takes one more byte, then ready drops until the slots drain.
// Reset (i_rst_n low, synchronous) empties both registers and puts the
// scanner between tokens at line 1.
module c_subset_lexer_unit #(
    parameter int VALUE_BITS = 32,
    parameter int LINE_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_in_byte,
    input  logic                    i_end_of_input,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [3:0]              o_result_kind,
    output logic [7:0]              o_text_byte,
    output logic [VALUE_BITS-1:0]   o_token_value,
    output logic [4:0]              o_number_radix,
    output logic [7:0]              o_sub_code,
    output logic [LINE_BITS-1:0]    o_line_number,
    output logic                    o_last_result
);
    import csl_pkg::*;

    logic                           r_in_valid;
    logic [7:0]                     r_byte;
    logic                           r_end;
    logic                           step;
    logic                           can_load;
    t_res [2:0]                     scan_res;
    logic [2:0][VALUE_BITS-1:0]     scan_val;
    logic [1:0]                     scan_cnt;
    logic [LINE_BITS-1:0]           scan_line;
    t_res                           out_res;

    assign step    = r_in_valid && can_load;
    assign o_ready = !r_in_valid || step;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_in_byte;
            r_end  <= i_end_of_input;
        end
    end

    csl_scan #(
        .VALUE_BITS (VALUE_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_byte),
        .i_end   (r_end),
        .o_res   (scan_res),
        .o_val   (scan_val),
        .o_cnt   (scan_cnt),
        .o_line  (scan_line)
    );

    csl_outbuf #(
        .VALUE_BITS (VALUE_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_res      (scan_res),
        .i_val      (scan_val),
        .i_cnt      (scan_cnt),
        .i_line     (scan_line),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res),
        .o_val      (o_token_value),
        .o_line     (o_line_number),
        .o_last     (o_last_result)
    );

    assign o_result_kind  = out_res.kind;
    assign o_text_byte    = out_res.text;
    assign o_number_radix = out_res.radix;
    assign o_sub_code     = out_res.sub;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csl_pkg::*;

    localparam int N_RANDOM   = 250;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 90;

    typedef struct {
        t_kind       kind;
        logic [7:0]  text;
        logic [31:0] value;
        logic [4:0]  radix;
        logic [7:0]  sub;
        logic [15:0] line;
        logic        last;
    } t_beat;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        logic       chk;
        t_kind      kind;
        logic [7:0] sub;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_result_kind;
    logic [7:0]  o_text_byte;
    logic [31:0] o_token_value;
    logic [4:0]  o_number_radix;
    logic [7:0]  o_sub_code;
    logic [15:0] o_line_number;
    logic        o_last_result;

    c_subset_lexer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_text_byte    (o_text_byte),
        .o_token_value  (o_token_value),
        .o_number_radix (o_number_radix),
        .o_sub_code     (o_sub_code),
        .o_line_number  (o_line_number),
        .o_last_result  (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    // Scanner state mirrored by the token predictor
    t_mode       lx_mode;
    logic [7:0]  lx_op_char;
    logic [31:0] lx_acc;
    logic [4:0]  lx_radix;
    logic        lx_stop;
    logic [9:0]  lx_kw_mask;
    logic [2:0]  lx_id_len;
    logic [7:0]  lx_chr;
    logic [15:0] lx_line;

    t_beat       token_q[$];
    logic [7:0]  src_bytes[$];
    logic        src_eoi[$];
    int          errors = 0;
    int          sent = 0;
    int          beats_seen = 0;
    int          eof_seen = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;

    function automatic void lex_clear();
        lx_mode    = M_IDLE;
        lx_op_char = 8'h00;
        lx_acc     = '0;
        lx_radix   = 5'd10;
        lx_stop    = 1'b0;
        lx_kw_mask = 10'h3ff;
        lx_id_len  = 3'd0;
        lx_chr     = 8'h00;
        lx_line    = 16'd1;
    endfunction

    function automatic void push_tok(t_kind k, logic [7:0] t, logic [31:0] v,
                                     logic [4:0] r, logic [7:0] s);
        t_beat b;
        b.kind = k; b.text = t; b.value = v; b.radix = r; b.sub = s;
        b.line = lx_line; b.last = 1'b0;
        token_q.push_back(b);
    endfunction

    function automatic logic [4:0] hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        case (c)
            "n": return 8'h0a;
            "r": return 8'h0d;
            "t": return 8'h09;
            "b": return 8'h08;
            "0": return 8'h00;
            default: return c;
        endcase
    endfunction

    function automatic logic [7:0] lone_op(logic [7:0] p);
        case (p)
            "<": return OP_LT;
            ">": return OP_GT;
            "=": return OP_ASSIGN;
            "*": return OP_MUL;
            "+": return OP_ADD;
            "-": return OP_SUB;
            "&": return OP_AND;
            "|": return OP_OR;
            "/": return OP_DIV;
            "%": return OP_MOD;
            "^": return OP_XOR;
            default: return OP_LNOT;
        endcase
    endfunction

    function automatic logic [7:0] eq_op(logic [7:0] p);
        case (p)
            "<": return OP_LE;
            ">": return OP_GE;
            "=": return OP_EQ;
            "*": return OP_MUL_EQ;
            "+": return OP_ADD_EQ;
            "-": return OP_SUB_EQ;
            "&": return OP_AND_EQ;
            "|": return OP_OR_EQ;
            "/": return OP_DIV_EQ;
            "%": return OP_MOD_EQ;
            "^": return OP_XOR_EQ;
            default: return OP_NE;
        endcase
    endfunction

    // Narrow the keyword candidates by one more identifier character
    function automatic void kw_track(logic [7:0] c);
        if (lx_id_len >= 6) begin
            lx_kw_mask = '0;
        end else begin
            for (int k = 0; k < NUM_KW; k++)
                if (KW_TEXT[k][47 - 8*lx_id_len -: 8] != c) lx_kw_mask[k] = 1'b0;
        end
        if (lx_id_len < 7) lx_id_len = lx_id_len + 3'd1;
    endfunction

    function automatic void ident_done();
        for (int k = 0; k < NUM_KW; k++) begin
            if (lx_kw_mask[k] && KW_LEN[k] == lx_id_len) begin
                push_tok(K_KW, 8'h00, '0, 5'd0, 8'(k));
                return;
            end
        end
        push_tok(K_ID, 8'h00, '0, 5'd0, 8'h00);
    endfunction

    function automatic void lex_begin(logic [7:0] c);
        lx_mode = M_IDLE;
        if (c == " " || c == 8'h0d || c == 8'h09) return;
        if (c == 8'h0a) begin
            if (lx_line != 16'hffff) lx_line++;
            return;
        end
        if (c >= "0" && c <= "9") begin
            push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
            lx_radix = 5'd10;
            lx_stop  = 1'b0;
            lx_acc   = 32'(c - "0");
            lx_mode  = (c == "0") ? M_NUM0 : M_NUM;
            return;
        end
        if (word_char(c)) begin
            lx_kw_mask = 10'h3ff;
            lx_id_len  = 3'd0;
            kw_track(c);
            push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
            lx_mode = M_IDENT;
            return;
        end
        case (c)
            "\"": lx_mode = M_STR;
            "'":  lx_mode = M_CHR_OPEN;
            "{", "}", "(", ")", "[", "]", ",", ";":
                push_tok(K_SEP, 8'h00, '0, 5'd0, c);
            "<", ">", "=", "*", "+", "-", "&", "|", "/", "%", "^", "!": begin
                lx_op_char = c;
                lx_mode = M_OP1;
            end
            "~": push_tok(K_OP, 8'h00, '0, 5'd0, OP_BNOT);
            default: begin
                push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
                push_tok(K_ERR, c, '0, 5'd0, 8'h00);
            end
        endcase
    endfunction

    function automatic void num_digit(logic [7:0] c);
        logic [4:0] d;
        d = hex_val(c);
        if (d == 5'd16) begin
            push_tok(K_NUM, 8'h00, lx_acc, lx_radix, 8'h00);
            lex_begin(c);
            return;
        end
        push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
        if (!lx_stop) begin
            if (d < lx_radix) lx_acc = lx_acc * lx_radix + d;
            else lx_stop = 1'b1;
        end
    endfunction

    // Work out the results of one input beat and queue them
    function automatic void lex_predict(logic [7:0] c, logic eoi);
        int n0;
        logic [7:0] p;
        n0 = token_q.size();
        p = lx_op_char;
        if (eoi) begin
            case (lx_mode)
                M_NUM0, M_NUM: push_tok(K_NUM, 8'h00, lx_acc, lx_radix, 8'h00);
                M_IDENT: ident_done();
                M_STR, M_STR_ESC, M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE:
                    push_tok(K_ERR, 8'h00, '0, 5'd0, 8'h00);
                M_OP1: push_tok(K_OP, 8'h00, '0, 5'd0, lone_op(p));
                M_SHIFT: push_tok(K_OP, 8'h00, '0, 5'd0, p == ">" ? OP_SHR : OP_SHL);
                default: ;
            endcase
            push_tok(K_EOF, 8'h00, '0, 5'd0, 8'h00);
            lex_clear();
        end else begin
            case (lx_mode)
                M_NUM0: begin
                    if (c == "b" || c == "B" || c == "x" || c == "X") begin
                        push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
                        lx_radix = (c == "b" || c == "B") ? 5'd2 : 5'd16;
                        lx_acc = '0;
                        lx_mode = M_NUM;
                    end else begin
                        lx_radix = (c >= "0" && c <= "7") ? 5'd8 : 5'd10;
                        lx_mode = M_NUM;
                        num_digit(c);
                    end
                end
                M_NUM: num_digit(c);
                M_IDENT: begin
                    if (word_char(c)) begin
                        kw_track(c);
                        push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
                    end else begin
                        ident_done();
                        lex_begin(c);
                    end
                end
                M_STR: begin
                    if (c == "\"") begin
                        push_tok(K_STR, 8'h00, '0, 5'd0, 8'h00);
                        lx_mode = M_IDLE;
                    end else if (c == "\\") lx_mode = M_STR_ESC;
                    else push_tok(K_TEXT, c, '0, 5'd0, 8'h00);
                end
                M_STR_ESC: begin
                    push_tok(K_TEXT, unescape(c), '0, 5'd0, 8'h00);
                    lx_mode = M_STR;
                end
                M_CHR_OPEN: begin
                    if (c == "\\") lx_mode = M_CHR_ESC;
                    else begin
                        lx_chr = c;
                        lx_mode = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC: begin
                    lx_chr = unescape(c);
                    lx_mode = M_CHR_CLOSE;
                end
                M_CHR_CLOSE: begin
                    if (c == "'") begin
                        push_tok(K_CHR, 8'h00, 32'(lx_chr), 5'd0, 8'h00);
                        lx_mode = M_IDLE;
                    end else begin
                        push_tok(K_ERR, c, '0, 5'd0, 8'h00);
                        lex_begin(c);
                    end
                end
                M_OP1: begin
                    if (c == "=") begin
                        push_tok(K_OP, 8'h00, '0, 5'd0, eq_op(p));
                        lx_mode = M_IDLE;
                    end else if (c == p && (p == "<" || p == ">")) begin
                        lx_mode = M_SHIFT;
                    end else if (c == p && p == "/") begin
                        lx_mode = M_COMMENT;
                    end else if (c == p && (p == "+" || p == "-" || p == "&" || p == "|"))
                    begin
                        push_tok(K_OP, 8'h00, '0, 5'd0, p == "+" ? OP_INC :
                                 p == "-" ? OP_DEC : p == "&" ? OP_LAND : OP_LOR);
                        lx_mode = M_IDLE;
                    end else begin
                        push_tok(K_OP, 8'h00, '0, 5'd0, lone_op(p));
                        lex_begin(c);
                    end
                end
                M_SHIFT: begin
                    if (c == "=") begin
                        push_tok(K_OP, 8'h00, '0, 5'd0, p == ">" ? OP_SHR_EQ : OP_SHL_EQ);
                        lx_mode = M_IDLE;
                    end else begin
                        push_tok(K_OP, 8'h00, '0, 5'd0, p == ">" ? OP_SHR : OP_SHL);
                        lex_begin(c);
                    end
                end
                M_COMMENT: if (c == 8'h0a) lex_begin(c);
                default: lex_begin(c);
            endcase
        end
        if (token_q.size() > n0) token_q[$].last = 1'b1;
    endfunction

    // Random source text, mostly well-formed tokens
    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            src_bytes.push_back(s[i]);
            src_eoi.push_back(1'b0);
        end
    endfunction

    function automatic string pick(string s);
        return string'(s[$urandom_range(0, s.len() - 1)]);
    endfunction

    function automatic void add_fragment();
        string dig = "0123456789abcdefABCDEF";
        string idc = "_azAZqxy09kvwe";
        string frag = "";
        int n;
        if ($urandom_range(0, 24) == 0) begin
            src_bytes.push_back(8'($urandom_range(0, 255)));
            src_eoi.push_back(1'b1);
            return;
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0: frag = "0x";
                    1: frag = "0b";
                    2: frag = "0";
                    default: frag = {frag, pick("123456789")};
                endcase
                n = $urandom_range(0, 5);
                repeat (n) frag = {frag, pick(dig)};
                if ($urandom_range(0, 5) == 0) repeat (8) frag = {frag, pick("fF9")};
            end
            2, 3: begin
                if ($urandom_range(0, 1)) begin
                    n = $urandom_range(0, NUM_KW - 1);
                    for (int i = 0; i < KW_LEN[n]; i++)
                        frag = {frag, string'(KW_TEXT[n][47 - 8*i -: 8])};
                    if ($urandom_range(0, 3) == 0) frag = {frag, pick(idc)};
                end else begin
                    frag = {frag, pick("_abcxyzQ")};
                    n = $urandom_range(0, 8);
                    repeat (n) frag = {frag, pick(idc)};
                end
            end
            4: begin
                frag = "\"";
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 2) == 0) frag = {frag, "\\", pick("nrtb0q\"\\")};
                    else frag = {frag, 8'($urandom_range(32, 126)) == "\"" ? "a" :
                                 string'(8'($urandom_range(32, 126)))};
                end
                if ($urandom_range(0, 7) != 0) frag = {frag, "\""};
            end
            5: begin
                frag = "'";
                if ($urandom_range(0, 2) == 0) frag = {frag, "\\", pick("nrtb0'x")};
                else frag = {frag, pick("az09 \"'")};
                if ($urandom_range(0, 4) != 0) frag = {frag, "'"};
            end
            6: begin
                frag = {frag, pick("<>=*+-&|%^!~/")};
                if (frag == "/") frag = {frag, pick("= a")};
                else frag = {frag, pick("=<>+-&| 1")};
                if ($urandom_range(0, 3) == 0) frag = {frag, "="};
            end
            7: frag = {frag, pick("{}()[],;"), pick(" \t\r\n")};
            8: begin
                frag = "//";
                n = $urandom_range(0, 6);
                repeat (n) frag = {frag, pick("ab/ \"'*")};
                add_str(frag);
                src_bytes.push_back(8'($urandom_range(128, 255)));
                src_eoi.push_back(1'b0);
                frag = "\n";
            end
            default: begin
                src_bytes.push_back(8'($urandom_range(0, 255)));
                src_eoi.push_back(1'b0);
            end
        endcase
        add_str(frag);
        if ($urandom_range(0, 1)) add_str(pick(" \n\t"));
    endfunction

    // Offer one beat, then predict its results once it is accepted
    task automatic send_beat(logic [7:0] c, logic eoi);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_byte      <= eoi ? 8'($urandom_range(0, 255)) : c;
        i_end_of_input <= eoi;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        lex_predict(c, eoi);
        sent++;
    endtask

    // Receiver: random hold-off bursts, one long hold, none at the end
    int hold_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (long_hold) begin
            i_ready <= 1'b0;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_beat x;
        if (i_rst_n && o_valid && i_ready) begin
            beats_seen++;
            if (token_q.size() == 0) begin
                $error("unexpected result beat kind=%0d", o_result_kind);
                errors++;
            end else begin
                x = token_q.pop_front();
                if (x.kind == K_EOF) eof_seen++;
                if (o_result_kind != x.kind) begin
                    $error("result_kind exp %0d got %0d", x.kind, o_result_kind);
                    errors++;
                end
                if (o_text_byte != x.text) begin
                    $error("text_byte exp %0h got %0h", x.text, o_text_byte);
                    errors++;
                end
                if (o_token_value != x.value) begin
                    $error("token_value exp %0h got %0h", x.value, o_token_value);
                    errors++;
                end
                if (o_number_radix != x.radix) begin
                    $error("number_radix exp %0d got %0d", x.radix, o_number_radix);
                    errors++;
                end
                if (o_sub_code != x.sub) begin
                    $error("sub_code exp %0d got %0d", x.sub, o_sub_code);
                    errors++;
                end
                if (o_line_number != x.line) begin
                    $error("line_number exp %0d got %0d", x.line, o_line_number);
                    errors++;
                end
                if (o_last_result != x.last) begin
                    $error("last_result exp %0b got %0b", x.last, o_last_result);
                    errors++;
                end
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("c_subset_lexer_unit regression: fail");
            $finish;
        end
    end

    // Long receiver stall while the sender keeps offering bytes
    initial begin
        wait (sent == 120);
        @(negedge i_clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        long_hold = 1'b0;
    end

    // Directed source: a binary prefix, digit stop, a string escape, bad char literal,
    // high and zero bytes, compound shift, a keyword, a newline and Eof
    t_row dir_rows[] = '{
        '{"0", 0, 0, K_TEXT, 8'h00}, '{"b", 0, 0, K_TEXT, 8'h00},
        '{"1", 0, 0, K_TEXT, 8'h00}, '{"2", 0, 0, K_TEXT, 8'h00},
        '{";", 0, 1, K_SEP, ";"},
        '{"\"", 0, 0, K_TEXT, 8'h00}, '{"\\", 0, 0, K_TEXT, 8'h00},
        '{"n", 0, 0, K_TEXT, 8'h00}, '{"\"", 0, 1, K_STR, 8'h00},
        '{"'", 0, 0, K_TEXT, 8'h00}, '{"x", 0, 0, K_TEXT, 8'h00},
        '{";", 0, 1, K_SEP, ";"},
        '{8'hff, 0, 1, K_ERR, 8'h00}, '{8'h00, 0, 1, K_ERR, 8'h00},
        '{"<", 0, 0, K_TEXT, 8'h00}, '{"<", 0, 0, K_TEXT, 8'h00},
        '{"=", 0, 1, K_OP, OP_SHL_EQ}, '{8'h0a, 0, 0, K_TEXT, 8'h00},
        '{"w", 0, 0, K_TEXT, 8'h00}, '{"h", 0, 0, K_TEXT, 8'h00},
        '{"i", 0, 0, K_TEXT, 8'h00}, '{"l", 0, 0, K_TEXT, 8'h00},
        '{"e", 0, 0, K_TEXT, 8'h00}, '{"~", 0, 1, K_OP, OP_BNOT},
        '{8'h00, 1, 1, K_EOF, 8'h00}
    };

    initial begin
        int total;
        lex_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].ch, dir_rows[i].eoi);
            if (dir_rows[i].chk &&
                (token_q[$].kind != dir_rows[i].kind || token_q[$].sub != dir_rows[i].sub))
            begin
                $error("directed row %0d: kind exp %0d got %0d", i,
                       dir_rows[i].kind, token_q[$].kind);
                errors++;
            end
        end

        // Random source, ending with a flush
        while (src_bytes.size() < N_RANDOM) add_fragment();
        src_bytes.push_back(8'h00);
        src_eoi.push_back(1'b1);
        total = src_bytes.size();
        for (int i = 0; i < total; i++) begin
            if (i == total / 2) begin
                i_valid <= 1'b0;
                while (token_q.size() != 0) @(posedge i_clk);
            end
            if (i == total * 85 / 100) quiet = 1'b1;
            send_beat(src_bytes[i], src_eoi[i]);
        end
        i_valid <= 1'b0;

        // Drain, then keep the clock running for anything stray
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Scanned %0d source beats into %0d result beats across %0d sources;",
                 sent, beats_seen, eof_seen);
        $display("numbers, literals, operators, keywords, comments and bad bytes mixed.");
        if (errors == 0) begin
            $display("c_subset_lexer_unit regression: pass");
        end else begin
            $display("c_subset_lexer_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- c_subset_lexer_unit.f -----
rtl/core/csl_pkg.sv
rtl/core/csl_scan.sv
rtl/core/csl_outbuf.sv
rtl/core/c_subset_lexer_unit.sv
tb/tb_top.sv
